// File: rtl/gate_event_evaluate_and_fanout_assert.svh
// assertion macros for the gate event evaluate and fanout block
`ifndef GATE_EVENT_EVALUATE_AND_FANOUT_ASSERT_SVH
`define GATE_EVENT_EVALUATE_AND_FANOUT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/geaf_pkg.sv
// types, codes and gate evaluation shared by the gate event block
package geaf_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned FAN_CNT_W   = 7;

    typedef logic [1:0] logic_t;

    localparam logic_t LOGIC_0 = 2'd0;
    localparam logic_t LOGIC_1 = 2'd1;
    localparam logic_t LOGIC_X = 2'd2;
    localparam logic_t LOGIC_Z = 2'd3;

    typedef enum logic [1:0] {
        OP_EVENT       = 2'd0,
        OP_LOAD_GATE   = 2'd1,
        OP_LOAD_OFFSET = 2'd2,
        OP_LOAD_ENTRY  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        GATE_BUF  = 3'd0,
        GATE_INV  = 3'd1,
        GATE_NAND = 3'd2,
        GATE_NOR  = 3'd3,
        GATE_AND  = 3'd4,
        GATE_OR   = 3'd5,
        GATE_XOR  = 3'd6,
        GATE_XNOR = 3'd7
    } gate_kind_t;

    typedef enum logic {
        CMD_ENTRY_WRITE = 1'b0,
        CMD_FANOUT      = 1'b1
    } cmd_kind_t;

    typedef enum logic {
        FS_IDLE = 1'b0,
        FS_EVAL = 1'b1
    } front_state_t;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        op_t        op;
        logic [31:0] time_stamp;
        logic [11:0] gate_index;
        logic        port;
        logic_t      logic_value;
        logic [13:0] table_index;
        logic [14:0] table_word;
        gate_kind_t  load_gate_type;
        logic [15:0] load_delay;
        logic_t      load_input0;
        logic_t      load_input1;
        logic_t      load_output;
    } in_item_t;

    typedef struct packed {
        logic [31:0] new_time;
        logic [11:0] target_gate;
        logic        target_port;
        logic_t      new_value;
        logic        last_event;
    } out_item_t;

    typedef struct packed {
        logic [11:0] gate;
        logic        port;
    } fan_entry_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [14:0]            addr;
        fan_entry_t             target;
        logic [FAN_CNT_W-1:0]   count;
        logic [31:0]            time_val;
        logic_t                 value;
    } queue_cmd_t;

    function automatic logic_t resolve_output(logic_t a, logic_t b, gate_kind_t kind);
        logic   one_a;
        logic   one_b;
        logic   zero_a;
        logic   zero_b;
        logic   known;
        logic_t res;
        one_a  = (a == LOGIC_1);
        one_b  = (b == LOGIC_1);
        zero_a = (a == LOGIC_0);
        zero_b = (b == LOGIC_0);
        known  = (zero_a || one_a) && (zero_b || one_b);
        unique case (kind)
            GATE_BUF:  res = a;
            GATE_INV:  res = zero_a ? LOGIC_1 : (one_a ? LOGIC_0 : a);
            GATE_NAND: res = (one_a && one_b) ? LOGIC_0 :
                             ((zero_a || zero_b) ? LOGIC_1 : LOGIC_X);
            GATE_NOR:  res = (one_a || one_b) ? LOGIC_0 :
                             ((zero_a && zero_b) ? LOGIC_1 : LOGIC_X);
            GATE_AND:  res = (one_a && one_b) ? LOGIC_1 :
                             ((zero_a || zero_b) ? LOGIC_0 : LOGIC_X);
            GATE_OR:   res = (one_a || one_b) ? LOGIC_1 :
                             ((zero_a && zero_b) ? LOGIC_0 : LOGIC_X);
            GATE_XOR:  res = known ? (a ^ b) : LOGIC_X;
            GATE_XNOR: res = known ? (LOGIC_1 ^ a ^ b) : LOGIC_X;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/gate_event_evaluate_and_fanout.sv
// top level: gate event evaluate and fanout
// load items do not hold busy themselves; an event holds busy in the cycle after it is taken, while it evaluates
// an event that changes its gate's output queues a fanout command in the evaluate state;
// the fanout back end then emits one result per cycle off its entry table read port
// busy also rises while the four-deep command queue is full; results cannot be stalled
// asynchronous active-low reset empties the queue and idles both ends; tables are not cleared
`include "gate_event_evaluate_and_fanout_assert.svh"
module gate_event_evaluate_and_fanout #(
    parameter int unsigned NUM_GATES   = 4096,
    parameter int unsigned NUM_EDGES   = 16384,
    parameter int unsigned MAX_FANOUT  = 64,
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  geaf_pkg::in_item_t     request,
    output logic                   result_valid,
    output geaf_pkg::out_item_t    result
);

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_empty;
    geaf_pkg::queue_cmd_t   q_push_cmd;
    geaf_pkg::queue_cmd_t   q_pop_cmd;
    logic                   ev_take;

    assign ev_take = start && !busy && request.op == geaf_pkg::OP_EVENT;

    geaf_front #(
        .NUM_GATES   (NUM_GATES),
        .NUM_EDGES   (NUM_EDGES),
        .MAX_FANOUT  (MAX_FANOUT),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd)
    );

    geaf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    geaf_back #(
        .NUM_EDGES (NUM_EDGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (q_pop_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

    `ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, q_push, !q_full || q_pop)
    `ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, q_pop, !q_empty)
    `ASSERT_NEXT(a_event_holds_busy, clk, rst_n, ev_take, busy)
    `ASSERT_NEXT(a_burst_contiguous, clk, rst_n, result_valid && !result.last_event, result_valid)

endmodule

// File: rtl/geaf_queue.sv
// command queue between the evaluate front end and the fanout back end
module geaf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  geaf_pkg::queue_cmd_t   push_cmd,
    output logic                   full,
    input  logic                   pop,
    output geaf_pkg::queue_cmd_t   pop_cmd,
    output logic                   empty
);

    geaf_pkg::queue_cmd_t              slot_reg [geaf_pkg::QUEUE_DEPTH];
    logic [geaf_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [geaf_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [geaf_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [geaf_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [geaf_pkg::QUEUE_AW:0]       cnt_reg;
    logic [geaf_pkg::QUEUE_AW:0]       cnt_next;

    assign full    = (cnt_reg == (geaf_pkg::QUEUE_AW + 1)'(geaf_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/geaf_front.sv
// front end: takes items, loads records and offsets, queues entry loads, evaluates gate events
module geaf_front #(
    parameter int unsigned NUM_GATES   = 4096,
    parameter int unsigned NUM_EDGES   = 16384,
    parameter int unsigned MAX_FANOUT  = 64,
    parameter int unsigned DELAY_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  geaf_pkg::in_item_t     request,
    input  logic                   q_full,
    output logic                   q_push,
    output geaf_pkg::queue_cmd_t   q_cmd
);

    localparam int unsigned GIW = $clog2(NUM_GATES);
    localparam int unsigned OIW = $clog2(NUM_GATES + 1);

    typedef struct packed {
        logic [DELAY_WIDTH-1:0] delay;
        geaf_pkg::gate_kind_t   kind;
        geaf_pkg::logic_t       in0;
        geaf_pkg::logic_t       in1;
        geaf_pkg::logic_t       out;
    } rec_t;

    rec_t                       rec_mem [NUM_GATES];
    logic [14:0]                off_mem [NUM_GATES + 1];

    geaf_pkg::front_state_t     state_reg;
    geaf_pkg::front_state_t     state_next;

    logic                       ev_valid_reg;
    logic [GIW-1:0]             ev_gate_reg;
    logic                       ev_port_reg;
    geaf_pkg::logic_t           ev_value_reg;
    logic [31:0]                ev_time_reg;
    rec_t                       rec_rd_reg;
    logic [14:0]                off_lo_reg;
    logic [14:0]                off_hi_reg;

    logic                       accept;
    logic                       gate_ok;
    logic                       offset_ok;
    logic                       entry_ok;
    rec_t                       rec_upd;
    rec_t                       rec_load;
    logic                       changed;
    logic [14:0]                end_c;
    logic [14:0]                span;
    logic                       rec_we;
    logic [GIW-1:0]             rec_waddr;
    rec_t                       rec_wdata;

    assign accept    = start && !busy;
    assign gate_ok   = (32'(request.gate_index) < NUM_GATES);
    assign offset_ok = (32'(request.table_index) <= NUM_GATES);
    assign entry_ok  = (32'(request.table_index) < NUM_EDGES);

    always_comb
    begin
        rec_load.delay = DELAY_WIDTH'(request.load_delay);
        rec_load.kind  = request.load_gate_type;
        rec_load.in0   = request.load_input0;
        rec_load.in1   = request.load_input1;
        rec_load.out   = request.load_output;

        rec_upd = rec_rd_reg;
        if (ev_port_reg)
        begin
            rec_upd.in1 = ev_value_reg;
        end
        else
        begin
            rec_upd.in0 = ev_value_reg;
        end
        rec_upd.out = geaf_pkg::resolve_output(rec_upd.in0, rec_upd.in1, rec_upd.kind);
        changed     = (rec_upd.out != rec_rd_reg.out);

        end_c = (32'(off_hi_reg) > NUM_EDGES) ? 15'(NUM_EDGES) : off_hi_reg;
        span  = end_c - off_lo_reg;
    end

    // single write port for record loads and event write-back
    always_comb
    begin
        rec_we    = 1'b0;
        rec_waddr = ev_gate_reg;
        rec_wdata = rec_upd;
        if (state_reg == geaf_pkg::FS_EVAL)
        begin
            rec_we = ev_valid_reg;
        end
        else if (accept && request.op == geaf_pkg::OP_LOAD_GATE && gate_ok)
        begin
            rec_we    = 1'b1;
            rec_waddr = GIW'(request.gate_index);
            rec_wdata = rec_load;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = q_full;
        q_push     = 1'b0;

        q_cmd.kind     = geaf_pkg::CMD_FANOUT;
        q_cmd.addr     = off_lo_reg;
        q_cmd.target   = '{gate: request.gate_index, port: request.port};
        q_cmd.count    = (32'(span) > MAX_FANOUT) ? geaf_pkg::FAN_CNT_W'(MAX_FANOUT)
                                                  : geaf_pkg::FAN_CNT_W'(span);
        q_cmd.time_val = ev_time_reg + 32'(rec_rd_reg.delay);
        q_cmd.value    = rec_upd.out;

        unique case (state_reg)
            geaf_pkg::FS_IDLE:
            begin
                if (accept && request.op == geaf_pkg::OP_EVENT)
                begin
                    state_next = geaf_pkg::FS_EVAL;
                end
                if (accept && request.op == geaf_pkg::OP_LOAD_ENTRY && entry_ok)
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = geaf_pkg::CMD_ENTRY_WRITE;
                    q_cmd.addr = 15'(request.table_index);
                end
            end
            geaf_pkg::FS_EVAL:
            begin
                busy       = 1'b1;
                state_next = geaf_pkg::FS_IDLE;
                q_push     = ev_valid_reg && changed && (off_lo_reg < end_c);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= geaf_pkg::FS_IDLE;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ev_valid_reg <= (request.op == geaf_pkg::OP_EVENT) && gate_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_gate_reg  <= GIW'(request.gate_index);
            ev_port_reg  <= request.port;
            ev_value_reg <= request.logic_value;
            ev_time_reg  <= request.time_stamp;
        end
        if (accept && request.op == geaf_pkg::OP_EVENT && gate_ok)
        begin
            rec_rd_reg <= rec_mem[GIW'(request.gate_index)];
            off_lo_reg <= off_mem[OIW'(request.gate_index)];
            off_hi_reg <= off_mem[OIW'(request.gate_index) + OIW'(1)];
        end
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (accept && request.op == geaf_pkg::OP_LOAD_OFFSET && offset_ok)
        begin
            off_mem[OIW'(request.table_index)] <= request.table_word;
        end
    end

endmodule

// File: rtl/geaf_back.sv
// back end: fanout entry table writes and one emitted event per cycle while a fanout runs
module geaf_back #(
    parameter int unsigned NUM_EDGES = 16384
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  geaf_pkg::queue_cmd_t   q_cmd,
    output logic                   q_pop,
    output logic                   result_valid,
    output geaf_pkg::out_item_t    result
);

    localparam int unsigned EIW = $clog2(NUM_EDGES);

    geaf_pkg::fan_entry_t               ent_mem [NUM_EDGES];

    geaf_pkg::back_state_t              state_reg;
    geaf_pkg::back_state_t              state_next;
    logic [14:0]                        pos_reg;
    logic [geaf_pkg::FAN_CNT_W-1:0]     rem_reg;
    logic [31:0]                        time_reg;
    geaf_pkg::logic_t                   value_reg;

    logic                               rd_en;
    logic                               last;

    geaf_pkg::fan_entry_t               ent_rd_reg;
    logic [31:0]                        out_time_reg;
    geaf_pkg::logic_t                   out_value_reg;
    logic                               out_last_reg;
    logic                               out_vld_reg;

    assign last = (rem_reg == geaf_pkg::FAN_CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            geaf_pkg::BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == geaf_pkg::CMD_FANOUT)
                    begin
                        state_next = geaf_pkg::BS_RUN;
                    end
                end
            end
            geaf_pkg::BS_RUN:
            begin
                rd_en = 1'b1;
                if (last)
                begin
                    state_next = geaf_pkg::BS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= geaf_pkg::BS_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.kind == geaf_pkg::CMD_FANOUT)
        begin
            pos_reg   <= q_cmd.addr;
            rem_reg   <= q_cmd.count;
            time_reg  <= q_cmd.time_val;
            value_reg <= q_cmd.value;
        end
        else if (rd_en)
        begin
            pos_reg <= pos_reg + 15'd1;
            rem_reg <= rem_reg - 1'b1;
        end
        if (q_pop && q_cmd.kind == geaf_pkg::CMD_ENTRY_WRITE)
        begin
            ent_mem[EIW'(q_cmd.addr)] <= q_cmd.target;
        end
        if (rd_en)
        begin
            ent_rd_reg    <= ent_mem[EIW'(pos_reg)];
            out_time_reg  <= time_reg;
            out_value_reg <= value_reg;
            out_last_reg  <= last;
        end
    end

    assign result_valid       = out_vld_reg;
    assign result.new_time    = out_time_reg;
    assign result.target_gate = ent_rd_reg.gate;
    assign result.target_port = ent_rd_reg.port;
    assign result.new_value   = out_value_reg;
    assign result.last_event  = out_last_reg;

endmodule
